### src/ternary_packed_group_dot_defines.svh
// ============================================================================
// ternary_packed_group_dot assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ============================================================================
`ifndef TERNARY_PACKED_GROUP_DOT_DEFINES_SVH
`define TERNARY_PACKED_GROUP_DOT_DEFINES_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define TPGD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tpgd assertion failed");

// condition never holds outside reset
`define TPGD_NEVER(label, clk, rstn, cond) \
    `TPGD_ASSERT(label, clk, rstn, !(cond))

`else

`define TPGD_ASSERT(label, clk, rstn, prop)

`define TPGD_NEVER(label, clk, rstn, cond)

`endif

`endif

### src/tpgd_pkg.sv
// ============================================================================
// tpgd_pkg
// Shared widths, weight codes, queue entry type and the 2-bit code multiply.
// ============================================================================
package tpgd_pkg;

    localparam int ACT_W       = 8;
    localparam int SCALE_W     = 16;
    localparam int GSUM_W      = 17;
    localparam int PROD_W      = ACT_W + 2;
    localparam int DOT_W       = PROD_W + 2;
    localparam int ACC_W       = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [GSUM_W-1:0] GSUM_MAX = {1'b0, {(GSUM_W-1){1'b1}}};
    localparam logic signed [GSUM_W-1:0] GSUM_MIN = {1'b1, {(GSUM_W-1){1'b0}}};

    // 2-bit weight codes, weight = code - 1
    localparam logic [1:0] WCODE_NEG  = 2'd0;
    localparam logic [1:0] WCODE_ZERO = 2'd1;
    localparam logic [1:0] WCODE_POS  = 2'd2;
    localparam logic [1:0] WCODE_DBL  = 2'd3;

    typedef struct packed {
        logic signed [GSUM_W-1:0] gsum;
        logic [SCALE_W-1:0]       act_scale;
        logic [SCALE_W-1:0]       weight_scale;
        logic                     fold;
        logic                     emit;
    } grp_entry_t;

    localparam int ENTRY_W = $bits(grp_entry_t);

    function automatic logic signed [PROD_W-1:0] code_mul(
        input logic [1:0]              code,
        input logic signed [ACT_W-1:0] act
    );
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] r;
        a = PROD_W'(act);
        case (code)
            WCODE_NEG:  r = -a;
            WCODE_ZERO: r = '0;
            WCODE_POS:  r = a;
            WCODE_DBL:  r = a <<< 1;
            default:    r = '0;
        endcase
        return r;
    endfunction

endpackage

### src/tpgd_front.sv
// ============================================================================
// tpgd_front
// Accepts beats, sums the four code products into the group sum and queues
// one entry at every group end or output end.
// ============================================================================
module tpgd_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           weight_byte,
    input  logic signed [tpgd_pkg::ACT_W-1:0]    act_a,
    input  logic signed [tpgd_pkg::ACT_W-1:0]    act_b,
    input  logic signed [tpgd_pkg::ACT_W-1:0]    act_c,
    input  logic signed [tpgd_pkg::ACT_W-1:0]    act_d,
    input  logic [tpgd_pkg::SCALE_W-1:0]         act_scale,
    input  logic [tpgd_pkg::SCALE_W-1:0]         weight_scale,
    input  logic                                 group_last,
    input  logic                                 output_last,
    input  logic                                 q_full,
    output logic                                 q_push,
    output tpgd_pkg::grp_entry_t                 q_data
);

    localparam int SUM_W = tpgd_pkg::GSUM_W + 2;

    logic signed [tpgd_pkg::GSUM_W-1:0] gsum_reg;
    logic signed [tpgd_pkg::GSUM_W-1:0] gsum_next;
    logic signed [tpgd_pkg::DOT_W-1:0]  dot;
    logic signed [SUM_W-1:0]            wide_sum;
    logic signed [tpgd_pkg::GSUM_W-1:0] gsum_sat;
    logic                               accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        dot = tpgd_pkg::DOT_W'(tpgd_pkg::code_mul(weight_byte[1:0], act_a))
            + tpgd_pkg::DOT_W'(tpgd_pkg::code_mul(weight_byte[3:2], act_b))
            + tpgd_pkg::DOT_W'(tpgd_pkg::code_mul(weight_byte[5:4], act_c))
            + tpgd_pkg::DOT_W'(tpgd_pkg::code_mul(weight_byte[7:6], act_d));
        wide_sum = SUM_W'(gsum_reg) + SUM_W'(dot);
        if (wide_sum > SUM_W'(tpgd_pkg::GSUM_MAX)) begin
            gsum_sat = tpgd_pkg::GSUM_MAX;
        end else if (wide_sum < SUM_W'(tpgd_pkg::GSUM_MIN)) begin
            gsum_sat = tpgd_pkg::GSUM_MIN;
        end else begin
            gsum_sat = wide_sum[tpgd_pkg::GSUM_W-1:0];
        end
    end

    always_comb begin
        gsum_next = gsum_reg;
        if (accept) begin
            // a group end folds the sum downstream and restarts it
            gsum_next = group_last ? '0 : gsum_sat;
        end
    end

    always_comb begin
        q_push              = accept && (group_last || output_last);
        q_data.gsum         = gsum_sat;
        q_data.act_scale    = act_scale;
        q_data.weight_scale = weight_scale;
        q_data.fold         = group_last;
        q_data.emit         = output_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gsum_reg <= '0;
        end else begin
            gsum_reg <= gsum_next;
        end
    end

endmodule

### src/tpgd_fifo.sv
// ============================================================================
// tpgd_fifo
// Short queue of group entries between the front and the back.
// ============================================================================
`include "ternary_packed_group_dot_defines.svh"

module tpgd_fifo #(
    parameter int DEPTH = tpgd_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tpgd_pkg::grp_entry_t push_data,
    output logic                 full,
    input  logic                 pop,
    output tpgd_pkg::grp_entry_t pop_data,
    output logic                 empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tpgd_pkg::grp_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TPGD_NEVER(a_no_push_full, aclk, aresetn, push && full)
    `TPGD_NEVER(a_no_pop_empty, aclk, aresetn, pop && empty)
    `TPGD_ASSERT(a_empty_ptrs, aclk, aresetn, empty |-> (wr_ptr_reg == rd_ptr_reg))

endmodule

### src/tpgd_back.sv
// ============================================================================
// tpgd_back
// Scales each folded group sum, adds it into the saturating accumulator and
// emits the accumulator at output ends.
// ============================================================================
`include "ternary_packed_group_dot_defines.svh"

module tpgd_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_empty,
    output logic                               q_pop,
    input  tpgd_pkg::grp_entry_t               q_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [tpgd_pkg::ACC_W-1:0]  out_value
);

    localparam int SC_W   = 2 * tpgd_pkg::SCALE_W;
    localparam int TERM_W = tpgd_pkg::GSUM_W + SC_W + 1;
    localparam int WIDE_W = tpgd_pkg::ACC_W + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCALE = 2'd1;
    localparam logic [1:0] ST_TERM  = 2'd2;
    localparam logic [1:0] ST_ACC   = 2'd3;

    localparam logic signed [tpgd_pkg::ACC_W-1:0] ACC_MAX =
        {1'b0, {(tpgd_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [tpgd_pkg::ACC_W-1:0] ACC_MIN =
        {1'b1, {(tpgd_pkg::ACC_W-1){1'b0}}};

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    tpgd_pkg::grp_entry_t               ent_reg;
    tpgd_pkg::grp_entry_t               ent_next;
    logic [SC_W-1:0]                    scale_reg;
    logic [SC_W-1:0]                    scale_next;
    logic signed [TERM_W-1:0]           term_reg;
    logic signed [TERM_W-1:0]           term_next;
    logic signed [tpgd_pkg::ACC_W-1:0]  acc_reg;
    logic signed [tpgd_pkg::ACC_W-1:0]  acc_next;
    logic signed [tpgd_pkg::ACC_W-1:0]  acc_sum;
    logic signed [WIDE_W-1:0]           wide_sum;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [tpgd_pkg::ACC_W-1:0]  out_data_reg;
    logic signed [tpgd_pkg::ACC_W-1:0]  out_data_next;
    logic                               advance;

    assign out_valid = out_valid_reg;
    assign out_value = out_data_reg;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    // an emitting entry waits while the output register is still held
    assign advance   = !ent_reg.emit || !out_valid_reg || out_ready;

    always_comb begin
        wide_sum = WIDE_W'(acc_reg) + WIDE_W'(term_reg);
        if (!ent_reg.fold) begin
            acc_sum = acc_reg;
        end else if (wide_sum[WIDE_W-1] != wide_sum[WIDE_W-2]) begin
            acc_sum = wide_sum[WIDE_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_sum = wide_sum[tpgd_pkg::ACC_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        scale_next     = scale_reg;
        term_next      = term_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    ent_next   = q_data;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                scale_next = SC_W'(ent_reg.act_scale) * SC_W'(ent_reg.weight_scale);
                state_next = ST_TERM;
            end
            ST_TERM: begin
                term_next  = ent_reg.gsum * $signed({1'b0, scale_reg});
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (advance) begin
                    if (ent_reg.emit) begin
                        out_valid_next = 1'b1;
                        out_data_next  = acc_sum;
                        acc_next       = '0;
                    end else begin
                        acc_next = acc_sum;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg      <= ent_next;
        scale_reg    <= scale_next;
        term_reg     <= term_next;
        out_data_reg <= out_data_next;
    end

    `TPGD_ASSERT(a_emit_clears, aclk, aresetn,
        (state_reg == ST_ACC && ent_reg.emit && advance) |=> (acc_reg == '0 && out_valid_reg))

endmodule

### src/ternary_packed_group_dot.sv
// ============================================================================
// ternary_packed_group_dot
// Group-scaled dot product of 2-bit packed weights with int8 activations.
// ============================================================================
// One beat carries a packed weight byte (four 2-bit codes, weight = code - 1)
// and four int8 activations; the front accepts a beat every cycle while the
// queue is not full and keeps the 17-bit saturating group sum. Beats flagged
// group end or output end (tuser / tlast) place an entry in a small queue; the
// back takes each entry through scale product, group term and saturating
// 64-bit add before it pops the next, so short groups can fill the queue and
// stall the front, the back's sequencer setting the pace. Scales are unsigned
// Q4.12, so m_axis_tdata is a signed value with 24 fraction bits, saturated,
// and the accumulator clears after each output.
module ternary_packed_group_dot #(
    parameter int QUEUE_DEPTH = tpgd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // weight_byte[7:0], act_a[15:8], act_b[23:16], act_c[31:24], act_d[39:32],
    // act_scale[55:40], weight_scale[71:56]
    input  logic [71:0] s_axis_tdata,
    // group_last[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_value[63:0]
    output logic [63:0] m_axis_tdata
);

    tpgd_pkg::grp_entry_t              push_data;
    tpgd_pkg::grp_entry_t              pop_data;
    logic                              q_push;
    logic                              q_pop;
    logic                              q_full;
    logic                              q_empty;
    logic signed [tpgd_pkg::ACC_W-1:0] out_value;

    tpgd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .weight_byte  (s_axis_tdata[7:0]),
        .act_a        ($signed(s_axis_tdata[15:8])),
        .act_b        ($signed(s_axis_tdata[23:16])),
        .act_c        ($signed(s_axis_tdata[31:24])),
        .act_d        ($signed(s_axis_tdata[39:32])),
        .act_scale    (s_axis_tdata[55:40]),
        .weight_scale (s_axis_tdata[71:56]),
        .group_last   (s_axis_tuser),
        .output_last  (s_axis_tlast),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (push_data)
    );

    tpgd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    tpgd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (pop_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (out_value)
    );

    assign m_axis_tdata = out_value;

endmodule

### tb/ternary_packed_group_dot_tb.sv
// ============================================================================
// ternary_packed_group_dot_tb
// Streams packed 2-bit weight beats with int8 activations into the block and
// checks every emitted dot product against a scoreboard that tracks the group
// sum and the saturating output accumulator beat by beat.
// ============================================================================
`timescale 1ns / 1ps

module ternary_packed_group_dot_tb;

    typedef struct packed {
        logic [7:0]      wbyte;
        logic [3:0][7:0] acts;      // acts[0] pairs with code bits 1:0
        logic [15:0]     ascale;
        logic [15:0]     wscale;
        logic            grp_end;
        logic            out_end;
    } beat_t;

    class dot_scoreboard;
        logic signed [tpgd_pkg::GSUM_W-1:0] group_sum;
        logic signed [tpgd_pkg::ACC_W-1:0]  out_acc;
        logic [tpgd_pkg::ACC_W-1:0]         expected_q[$];
        int errors;
        int beats;
        int group_ends;
        int outputs;
        int checked;
        int gsum_clamps;
        int acc_clamps;

        function new();
            group_sum   = '0;
            out_acc     = '0;
            errors      = 0;
            beats       = 0;
            group_ends  = 0;
            outputs     = 0;
            checked     = 0;
            gsum_clamps = 0;
            acc_clamps  = 0;
        endfunction

        function void note_beat(beat_t b);
            int                                partial;
            int                                w;
            logic [31:0]                       scale;
            logic signed [tpgd_pkg::ACC_W-1:0] term;
            logic signed [tpgd_pkg::ACC_W:0]   wide;
            partial = group_sum;
            for (int k = 0; k < 4; k++) begin
                case (b.wbyte[2*k +: 2])
                    tpgd_pkg::WCODE_NEG:  w = -1;
                    tpgd_pkg::WCODE_ZERO: w = 0;
                    tpgd_pkg::WCODE_POS:  w = 1;
                    tpgd_pkg::WCODE_DBL:  w = 2;
                    default:              w = 0;
                endcase
                partial += w * int'($signed(b.acts[k]));
            end
            if (partial > int'(tpgd_pkg::GSUM_MAX)) begin
                partial = int'(tpgd_pkg::GSUM_MAX);
                gsum_clamps++;
            end else if (partial < int'(tpgd_pkg::GSUM_MIN)) begin
                partial = int'(tpgd_pkg::GSUM_MIN);
                gsum_clamps++;
            end
            group_sum = partial[tpgd_pkg::GSUM_W-1:0];
            beats++;

            if (b.grp_end) begin
                scale = 32'(b.ascale) * 32'(b.wscale);
                term  = longint'(group_sum) * longint'({32'b0, scale});
                wide  = {out_acc[tpgd_pkg::ACC_W-1], out_acc} + {term[tpgd_pkg::ACC_W-1], term};
                if (wide[tpgd_pkg::ACC_W] != wide[tpgd_pkg::ACC_W-1]) begin
                    out_acc = wide[tpgd_pkg::ACC_W] ? {1'b1, {(tpgd_pkg::ACC_W-1){1'b0}}}
                                                    : {1'b0, {(tpgd_pkg::ACC_W-1){1'b1}}};
                    acc_clamps++;
                end else begin
                    out_acc = wide[tpgd_pkg::ACC_W-1:0];
                end
                group_sum = '0;
                group_ends++;
            end

            if (b.out_end) begin
                expected_q.push_back(out_acc);
                out_acc = '0;
                outputs++;
            end
        endfunction

        function void check_out(logic [tpgd_pkg::ACC_W-1:0] got);
            logic [tpgd_pkg::ACC_W-1:0] want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected out_value beat: expected none, got %0d",
                         $time, $signed(got));
                errors++;
            end else begin
                want = expected_q.pop_front();
                checked++;
                if (want !== got) begin
                    $display("%0t: out_value mismatch: expected %0d, got %0d",
                             $time, $signed(want), $signed(got));
                    errors++;
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // weight_byte[7:0], act_a[15:8], act_b[23:16], act_c[31:24], act_d[39:32],
    // act_scale[55:40], weight_scale[71:56]
    logic [71:0] s_axis_tdata;
    // group_last[0]
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_value[63:0]
    logic [63:0] m_axis_tdata;

    dot_scoreboard sb;
    int            tx_idle_pct;
    int            tx_count;
    int            rx_idle_pct;
    int            hold_requests;
    int            hold_served;
    int            hold_left;

    ternary_packed_group_dot uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // result side: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_left   = 300;
            hold_served = hold_requests;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : monitor
        beat_t seen;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen.wbyte   = s_axis_tdata[7:0];
                seen.acts    = s_axis_tdata[39:8];
                seen.ascale  = s_axis_tdata[55:40];
                seen.wscale  = s_axis_tdata[71:56];
                seen.grp_end = s_axis_tuser;
                seen.out_end = s_axis_tlast;
                sb.note_beat(seen);
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_out(m_axis_tdata);
        end
    end

    function automatic beat_t mk(logic [7:0] wb, int a0, int a1, int a2, int a3,
                                 logic [15:0] asc, logic [15:0] wsc,
                                 logic gl, logic ol);
        beat_t b;
        b.wbyte   = wb;
        b.acts[0] = a0[7:0];
        b.acts[1] = a1[7:0];
        b.acts[2] = a2[7:0];
        b.acts[3] = a3[7:0];
        b.ascale  = asc;
        b.wscale  = wsc;
        b.grp_end = gl;
        b.out_end = ol;
        return b;
    endfunction

    function automatic logic [15:0] pick_scale();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(65535));
    endfunction

    function automatic beat_t rand_beat(logic gl, logic ol);
        beat_t b;
        int    r;
        b.wbyte = 8'($urandom_range(255));
        for (int k = 0; k < 4; k++) begin
            r = $urandom_range(15);
            case (r)
                0:       b.acts[k] = 8'd127;
                1:       b.acts[k] = 8'h81;   // -127
                2:       b.acts[k] = 8'h80;   // -128
                default: b.acts[k] = 8'($urandom_range(255));
            endcase
        end
        b.ascale  = pick_scale();
        b.wscale  = pick_scale();
        b.grp_end = gl;
        b.out_end = ol;
        return b;
    endfunction

    task automatic send_beat(beat_t b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.wscale, b.ascale, b.acts, b.wbyte};
        s_axis_tuser  <= b.grp_end;
        s_axis_tlast  <= b.out_end;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        tx_count++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_directed();
        send_beat(mk(8'hFF, 127, 127, 127, 127, 16'hFFFF, 16'hFFFF, 1, 1));
        send_beat(mk(8'h00, -128, -128, -128, -128, 16'hFFFF, 16'hFFFF, 1, 1));
        send_beat(mk(8'hFF, -128, -128, -128, -128, 16'hFFFF, 16'hFFFF, 1, 1));
        send_beat(mk(8'h55, 127, -128, 1, -1, 16'h1000, 16'h1000, 1, 1));
        // every code in one byte, then a multi-beat group
        send_beat(mk(8'hE4, 127, -127, -128, 5, 16'h1000, 16'h1000, 0, 0));
        send_beat(mk(8'hAA, 1, 2, 3, 4, 16'h0000, 16'h0000, 0, 0));
        send_beat(mk(8'h1B, -1, -2, -3, -4, 16'h0001, 16'hFFFF, 1, 0));
        send_beat(mk(8'h39, 100, -100, 50, -50, 16'h8000, 16'h0001, 1, 1));
        // output end with the group still open: partial sum carries over
        send_beat(mk(8'hC6, 10, 20, 30, 40, 16'hFFFF, 16'hFFFF, 0, 1));
        send_beat(mk(8'h27, 5, 6, 7, 8, 16'h1000, 16'h1000, 1, 1));
        send_beat(mk(8'hFF, 127, 127, 127, 127, 16'h0000, 16'hFFFF, 1, 0));
        send_beat(mk(8'h80, 0, 0, 0, -128, 16'hFFFF, 16'hFFFF, 1, 1));
        send_beat(mk(8'h0F, -128, 127, 0, 0, 16'hFFFF, 16'h0000, 1, 1));
        send_beat(mk(8'hF0, 1, 1, 127, -127, 16'h0000, 16'h0000, 0, 0));
        send_beat(mk(8'h3C, -7, 9, -128, 127, 16'h0000, 16'h0000, 0, 0));
        send_beat(mk(8'hD2, 64, -64, 32, -32, 16'h7FFF, 16'h8000, 1, 0));
        send_beat(mk(8'h6B, -100, 100, -1, 1, 16'h0FFF, 16'hF000, 1, 0));
        send_beat(mk(8'hFF, 127, 127, 127, 127, 16'hFFFF, 16'hFFFF, 1, 1));
        send_beat(mk(8'h00, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, 1));
        send_beat(mk(8'h00, 0, 0, 0, 0, 16'h0000, 16'h0000, 1, 1));
    endtask

    // one output of one to four groups, each group ends in a flagged beat
    task automatic send_output();
        int ngroups;
        int len;
        int r;
        ngroups = $urandom_range(1, 4);
        for (int g = 0; g < ngroups; g++) begin
            r = $urandom_range(99);
            if (r < 80)
                len = $urandom_range(1, 8);
            else if (r < 97)
                len = $urandom_range(9, 32);
            else
                len = 64;
            for (int i = 0; i < len; i++)
                send_beat(rand_beat(i == len - 1, (i == len - 1) && (g == ngroups - 1)));
        end
    endtask

    // group far past its nominal size, driven toward a group sum limit
    task automatic send_long_group();
        int    len;
        logic  neg;
        beat_t b;
        len = $urandom_range(66, 90);
        neg = 1'($urandom_range(1));
        for (int i = 0; i < len; i++) begin
            b = rand_beat(i == len - 1, (i == len - 1) && ($urandom_range(1) == 1));
            if ($urandom_range(3) != 0) begin
                b.wbyte = 8'hFF;
                b.acts  = neg ? {4{8'h80}} : {4{8'd127}};
            end
            send_beat(b);
        end
    endtask

    task automatic run_random(int n);
        int start;
        int r;
        int len;
        start = tx_count;
        while (tx_count - start < n) begin
            r = $urandom_range(99);
            if (r < 75) begin
                send_output();
            end else if (r < 80) begin
                send_long_group();
            end else if (r < 92) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_beat(rand_beat(1'($urandom_range(1)), 1'($urandom_range(1))));
            end else begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    send_beat(rand_beat(1'b0, i == len - 1));
            end
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        rx_idle_pct   <= 0;
        hold_requests <= 0;
        hold_served   = 0;
        hold_left     = 0;
        tx_idle_pct   = 0;
        tx_count      = 0;
        sb            = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_directed();
        wait_drained();

        tx_idle_pct = 28;
        rx_idle_pct <= 86;
        run_random(520);
        wait_drained();

        tx_idle_pct = 86;
        rx_idle_pct <= 28;
        run_random(520);
        wait_drained();

        // receiver holds off while single-beat outputs pile up
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 48; i++)
            send_beat(rand_beat(1'b1, 1'b1));
        run_random(520);

        wait_drained();
        repeat (40) @(posedge aclk);

        $display("run covered %0d beats, %0d group ends, %0d outputs, %0d results checked",
                 sb.beats, sb.group_ends, sb.outputs, sb.checked);
        $display("group sum pinned %0d times, accumulator pinned %0d times, %0d errors",
                 sb.gsum_clamps, sb.acc_clamps, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results still expected", $time, sb.expected_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/tpgd_pkg.sv
src/tpgd_front.sv
src/tpgd_fifo.sv
src/tpgd_back.sv
src/ternary_packed_group_dot.sv
tb/ternary_packed_group_dot_tb.sv
